>>> rtl/core/dsps_pkg.sv
// ----------------------------------------------------------------------------
// dsps_pkg - shared types for the dual server priority scheduler
// Table entry layout, result status codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package dsps_pkg;

	localparam logic [15:0] OrderMax = 16'hFFFF;

	typedef enum logic [0:0] {
		OP_ADD  = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_ARGS = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	// one stored task; priority and order together form the ranking key
	typedef struct packed {
		logic [7:0]  id;
		logic [7:0]  prio;
		logic [15:0] order;
		logic [15:0] remaining;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture the input transaction, clear scan state
		logic add_try;   // test the slot under the index, write it when free
		logic scan_rd;   // read the slot under the index for ranking
		logic serve0;    // serve the best task
		logic serve1;    // serve the runner-up task
		logic tick_inc;  // advance the tick counter
		logic load_out;  // move the result into the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_tick;   // raw input is a tick
		logic bad_args;  // raw input has zero priority or burst
		logic full;      // every slot is occupied
		logic idx_last;  // index sits on the last slot
		logic free_hit;  // slot under the index is free
	} stat_t;

endpackage

>>> rtl/core/dsps_ctrl.sv
// ----------------------------------------------------------------------------
// dsps_ctrl - sequencer for the dual server priority scheduler
// Walks each transaction through add search, table scan, service and result.
// ----------------------------------------------------------------------------
module dsps_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  dsps_pkg::stat_t stat,
	output dsps_pkg::cmd_t  cmd
);
	import dsps_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_ADD    = 7'b0000010,
		S_SCAN   = 7'b0000100,
		S_DRAIN  = 7'b0001000,
		S_SERVE0 = 7'b0010000,
		S_SERVE1 = 7'b0100000,
		S_FIN    = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (stat.is_tick) begin
						state_d = S_SCAN;
					end else if (stat.bad_args || stat.full) begin
						state_d = S_FIN;
					end else begin
						state_d = S_ADD;
					end
				end
			end
			S_ADD: begin
				cmd.add_try = 1'b1;
				if (stat.free_hit) begin
					state_d = S_FIN;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (stat.idx_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_SERVE0;
			end
			S_SERVE0: begin
				cmd.serve0 = 1'b1;
				state_d    = S_SERVE1;
			end
			S_SERVE1: begin
				cmd.serve1   = 1'b1;
				cmd.tick_inc = 1'b1;
				state_d      = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// hold state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/dsps_dp.sv
// ----------------------------------------------------------------------------
// dsps_dp - datapath of the dual server priority scheduler
// Task table memory, valid bits, slot scan with best/runner-up ranking,
// service write-back, counters and the result register.
// ----------------------------------------------------------------------------
module dsps_dp #(
	parameter int TABLE_SLOTS = 16,
	parameter int TIME_BITS   = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dsps_pkg::cmd_t  cmd,
	output dsps_pkg::stat_t stat,
	input  logic            operation,
	input  logic [7:0]      task_id,
	input  logic [7:0]      task_priority,
	input  logic [15:0]     burst_length,
	output logic [1:0]      status,
	output logic            first_busy,
	output logic [7:0]      first_task,
	output logic            first_finished,
	output logic            second_busy,
	output logic [7:0]      second_task,
	output logic            second_finished,
	output logic            table_empty,
	output logic [15:0]     time_now
);
	import dsps_pkg::*;

	localparam int IdxW = $clog2(TABLE_SLOTS);
	localparam int CntW = $clog2(TABLE_SLOTS + 1);

	// table storage
	entry_t                 mem [TABLE_SLOTS];
	logic [TABLE_SLOTS-1:0] valid_q;
	logic [CntW-1:0]        count_q;
	logic [15:0]            insert_q;
	logic [TIME_BITS-1:0]   tick_q;

	// captured transaction and scan state
	entry_t         item_q;
	logic [IdxW-1:0] idx_q;
	entry_t          rd_data_s1;
	logic [IdxW-1:0] rd_slot_s1;
	logic            rd_live_s1;
	logic            rd_valid_s1;
	entry_t          best_q, second_q;
	logic [IdxW-1:0] best_slot_q, second_slot_q;
	logic            has_best_q, has_second_q;

	// result under construction
	status_t    res_status_q;
	logic       res_b0_q, res_f0_q, res_b1_q, res_f1_q;
	logic [7:0] res_t0_q, res_t1_q;

	// service of the selected task
	entry_t          srv_entry;
	logic [IdxW-1:0] srv_slot;
	logic            srv_live;
	logic [15:0]     srv_rem;
	logic            srv_fin;

	// memory write port
	logic            wr_en;
	logic [IdxW-1:0] wr_addr;
	entry_t          wr_data;

	logic [23:0] cand_key, best_key, second_key;
	logic        cand_ok;

	assign stat.is_tick  = (operation == OP_TICK);
	assign stat.bad_args = (task_priority == 8'd0) || (burst_length == 16'd0);
	assign stat.full     = (count_q == CntW'(TABLE_SLOTS));
	assign stat.idx_last = (idx_q == IdxW'(TABLE_SLOTS - 1));
	assign stat.free_hit = !valid_q[idx_q];

	// pick the task being served and count it down
	always_comb begin
		srv_entry = cmd.serve1 ? second_q : best_q;
		srv_slot  = cmd.serve1 ? second_slot_q : best_slot_q;
		srv_live  = cmd.serve1 ? has_second_q : has_best_q;
		srv_rem   = (srv_entry.remaining == 16'd0) ? 16'd0 : srv_entry.remaining - 16'd1;
		srv_fin   = (srv_rem == 16'd0);
	end

	// steer the single write port between insertion and service
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = item_q;
		if (cmd.add_try) begin
			wr_en         = !valid_q[idx_q];
			wr_data.order = insert_q;
		end else if (cmd.serve0 || cmd.serve1) begin
			wr_en             = srv_live;
			wr_addr           = srv_slot;
			wr_data           = srv_entry;
			wr_data.remaining = srv_rem;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered table read for the scan
	always_ff @(posedge clk) begin
		if (cmd.scan_rd) begin
			rd_data_s1 <= mem[idx_q];
			rd_slot_s1 <= idx_q;
			rd_live_s1 <= valid_q[idx_q];
		end
	end

	// ranking: strictly smaller key wins, so equal keys keep the lower slot
	assign cand_key   = {rd_data_s1.prio, rd_data_s1.order};
	assign best_key   = {best_q.prio, best_q.order};
	assign second_key = {second_q.prio, second_q.order};
	assign cand_ok    = rd_valid_s1 && rd_live_s1;

	always_ff @(posedge clk) begin
		if (cand_ok) begin
			if (!has_best_q || (cand_key < best_key)) begin
				best_q        <= rd_data_s1;
				best_slot_q   <= rd_slot_s1;
				second_q      <= best_q;
				second_slot_q <= best_slot_q;
			end else if (!has_second_q || (cand_key < second_key)) begin
				second_q      <= rd_data_s1;
				second_slot_q <= rd_slot_s1;
			end
		end
	end

	// capture the transaction payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q.id        <= task_id;
			item_q.prio      <= task_priority;
			item_q.order     <= 16'd0;
			item_q.remaining <= burst_length;
		end
	end

	// control state: index, read pipe, candidate flags, table bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			rd_valid_s1  <= 1'b0;
			has_best_q   <= 1'b0;
			has_second_q <= 1'b0;
			valid_q      <= '0;
			count_q      <= '0;
			insert_q     <= '0;
			tick_q       <= '0;
		end else begin
			rd_valid_s1 <= cmd.scan_rd;
			if (cmd.load) begin
				idx_q        <= '0;
				has_best_q   <= 1'b0;
				has_second_q <= 1'b0;
			end else if (cmd.add_try || cmd.scan_rd) begin
				idx_q <= idx_q + IdxW'(1);
			end
			if (cand_ok) begin
				if (!has_best_q || (cand_key < best_key)) begin
					has_best_q   <= 1'b1;
					has_second_q <= has_best_q;
				end else if (!has_second_q || (cand_key < second_key)) begin
					has_second_q <= 1'b1;
				end
			end
			if (cmd.add_try && !valid_q[idx_q]) begin
				valid_q[idx_q] <= 1'b1;
				count_q        <= count_q + CntW'(1);
				if (insert_q != OrderMax) begin
					insert_q <= insert_q + 16'd1;
				end
			end
			if ((cmd.serve0 || cmd.serve1) && srv_live && srv_fin) begin
				valid_q[srv_slot] <= 1'b0;
				count_q           <= count_q - CntW'(1);
			end
			if (cmd.tick_inc && (tick_q != '1)) begin
				tick_q <= tick_q + TIME_BITS'(1);
			end
		end
	end

	// build the result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (operation == OP_TICK) begin
				res_status_q <= ST_OK;
			end else if (stat.bad_args) begin
				res_status_q <= ST_BAD_ARGS;
			end else if (stat.full) begin
				res_status_q <= ST_FULL;
			end else begin
				res_status_q <= ST_OK;
			end
			res_b0_q <= 1'b0;
			res_t0_q <= 8'd0;
			res_f0_q <= 1'b0;
			res_b1_q <= 1'b0;
			res_t1_q <= 8'd0;
			res_f1_q <= 1'b0;
		end
		if (cmd.serve0 && has_best_q) begin
			res_b0_q <= 1'b1;
			res_t0_q <= best_q.id;
			res_f0_q <= srv_fin;
		end
		if (cmd.serve1 && has_second_q) begin
			res_b1_q <= 1'b1;
			res_t1_q <= second_q.id;
			res_f1_q <= srv_fin;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status          <= res_status_q;
			first_busy      <= res_b0_q;
			first_task      <= res_t0_q;
			first_finished  <= res_f0_q;
			second_busy     <= res_b1_q;
			second_task     <= res_t1_q;
			second_finished <= res_f1_q;
			table_empty     <= (count_q == '0);
			time_now        <= 16'(tick_q);
		end
	end

endmodule

>>> rtl/core/dual_server_priority_scheduler.sv
// ----------------------------------------------------------------------------
// dual_server_priority_scheduler - task scheduler for two processors
// Adds tasks to a ready table; each tick runs the two best-ranked tasks.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | operation, task_id, task_priority,
//          |                      | burst_length
//  out     | out_valid / out_ready| status, first_*, second_*, table_empty,
//          |                      | time_now
//
// A tick first scans the table, reading one table entry a cycle through the
// single memory read port, then makes two service writes. A rejected add
// goes straight to the result; an accepted add first runs the free-slot
// search. One transaction is in flight at a time; the next is
// taken while the previous result waits in the output register.
// Reset empties the table at once through the valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module dual_server_priority_scheduler #(
	parameter int TABLE_SLOTS = 16,
	parameter int TIME_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [7:0]  task_id,
	input  logic [7:0]  task_priority,
	input  logic [15:0] burst_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        first_busy,
	output logic [7:0]  first_task,
	output logic        first_finished,
	output logic        second_busy,
	output logic [7:0]  second_task,
	output logic        second_finished,
	output logic        table_empty,
	output logic [15:0] time_now
);
	import dsps_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencer
	dsps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// table, ranking and result
	dsps_dp #(
		.TABLE_SLOTS (TABLE_SLOTS),
		.TIME_BITS   (TIME_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.operation       (operation),
		.task_id         (task_id),
		.task_priority   (task_priority),
		.burst_length    (burst_length),
		.status          (status),
		.first_busy      (first_busy),
		.first_task      (first_task),
		.first_finished  (first_finished),
		.second_busy     (second_busy),
		.second_task     (second_task),
		.second_finished (second_finished),
		.table_empty     (table_empty),
		.time_now        (time_now)
	);

endmodule

>>> rtl/core/dsps_chk.sv
// ----------------------------------------------------------------------------
// dsps_chk - port checker for the dual server priority scheduler
// Watches result transactions for consistency between status and busy flags.
// ----------------------------------------------------------------------------
module dsps_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic        first_busy,
	input logic [7:0]  first_task,
	input logic        first_finished,
	input logic        second_busy,
	input logic        second_finished,
	input logic        table_empty
);
	import dsps_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(first_task) && $stable(table_empty))
		else $error("stalled result changed");

	// a processor only finishes a task it ran
	a_fin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!first_finished || first_busy) && (!second_finished || second_busy))
		else $error("finish flag without busy processor");

	// processor 1 is busy only when processor 0 is
	a_busy_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && second_busy |-> first_busy)
		else $error("second processor busy while first idle");

	// a rejected add runs nothing
	a_reject_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> !first_busy && !second_busy && (first_task == 8'd0))
		else $error("rejected add reports a running task");

endmodule

bind dual_server_priority_scheduler dsps_chk u_dsps_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.status          (status),
	.first_busy      (first_busy),
	.first_task      (first_task),
	.first_finished  (first_finished),
	.second_busy     (second_busy),
	.second_finished (second_finished),
	.table_empty     (table_empty)
);

>>> tb/sv/scheduler_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scheduler_checker - result predictor and comparator for the scheduler
// Watches both channels of the dual server priority scheduler. Each accepted
// input transaction is run through a private copy of the ready table to
// predict its result. Each accepted result is compared field by field with
// the oldest prediction.
// ----------------------------------------------------------------------------
module scheduler_checker #(
	parameter int SLOTS     = 16,
	parameter int TIME_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        operation,
	input  logic [7:0]  task_id,
	input  logic [7:0]  task_priority,
	input  logic [15:0] burst_length,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	input  logic        first_busy,
	input  logic [7:0]  first_task,
	input  logic        first_finished,
	input  logic        second_busy,
	input  logic [7:0]  second_task,
	input  logic        second_finished,
	input  logic        table_empty,
	input  logic [15:0] time_now,
	output int          fail_count,
	output int          pending,
	output int          ticks_seen,
	output int          admitted,
	output int          bad_rejects,
	output int          full_rejects,
	output int          completions
);
	import dsps_pkg::*;

	typedef struct packed {
		status_t     status;
		logic        first_busy;
		logic [7:0]  first_task;
		logic        first_finished;
		logic        second_busy;
		logic [7:0]  second_task;
		logic        second_finished;
		logic        table_empty;
		logic [15:0] time_now;
	} sched_result_t;

	// private copy of the ready table
	logic [SLOTS-1:0]     occupied;
	logic [7:0]           task_ids   [SLOTS];
	logic [7:0]           prios      [SLOTS];
	logic [15:0]          left_ticks [SLOTS];
	logic [15:0]          arrival    [SLOTS];
	logic [15:0]          insert_count;
	logic [TIME_BITS-1:0] clock_ticks;

	sched_result_t due_results[$];
	int            results_checked;

	// true when slot a is ranked ahead of slot b
	function automatic bit ranks_ahead(int a, int b);
		if (prios[a] != prios[b])
			return prios[a] < prios[b];
		if (arrival[a] != arrival[b])
			return arrival[a] < arrival[b];
		return a < b;
	endfunction

	// take one unit of service from a slot; report whether it completed
	function automatic logic serve_slot(int s);
		if (left_ticks[s] != 16'd0)
			left_ticks[s] = left_ticks[s] - 16'd1;
		if (left_ticks[s] == 16'd0) begin
			occupied[s] = 1'b0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// advance the table by one transaction and build its result
	function automatic sched_result_t predict_schedule(op_t op, logic [7:0] id,
			logic [7:0] prio, logic [15:0] len);
		sched_result_t r;
		int best;
		int runner;
		int free_slot;
		r = '0;
		r.status = ST_OK;
		best = -1;
		runner = -1;
		free_slot = -1;
		if (op == OP_ADD) begin
			if (prio == 8'd0 || len == 16'd0) begin
				r.status = ST_BAD_ARGS;
			end else begin
				for (int i = SLOTS - 1; i >= 0; i--)
					if (!occupied[i])
						free_slot = i;
				if (free_slot < 0) begin
					r.status = ST_FULL;
				end else begin
					occupied[free_slot] = 1'b1;
					task_ids[free_slot] = id;
					prios[free_slot] = prio;
					left_ticks[free_slot] = len;
					arrival[free_slot] = insert_count;
					if (insert_count != OrderMax)
						insert_count = insert_count + 16'd1;
				end
			end
		end else begin
			// rank the table as it stands at the start of the tick
			for (int i = 0; i < SLOTS; i++) begin
				if (!occupied[i])
					continue;
				if (best < 0 || ranks_ahead(i, best)) begin
					runner = best;
					best = i;
				end else if (runner < 0 || ranks_ahead(i, runner)) begin
					runner = i;
				end
			end
			if (best >= 0) begin
				r.first_busy = 1'b1;
				r.first_task = task_ids[best];
				r.first_finished = serve_slot(best);
			end
			if (runner >= 0) begin
				r.second_busy = 1'b1;
				r.second_task = task_ids[runner];
				r.second_finished = serve_slot(runner);
			end
			if (clock_ticks != '1)
				clock_ticks = clock_ticks + TIME_BITS'(1);
		end
		r.table_empty = ~(|occupied);
		r.time_now = 16'(clock_ticks);
		return r;
	endfunction

	task automatic report_failure(string msg);
		$display("[%0t] scheduler_checker: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report_failure($sformatf("result %0d: %s is %0h, predicted %0h",
				results_checked, name, got, want));
	endtask

	// compare results, then predict for the newly accepted transaction
	always @(posedge clk or negedge arst_n) begin
		sched_result_t want;
		if (!arst_n) begin
			occupied = '0;
			insert_count = 16'd0;
			clock_ticks = '0;
			due_results.delete();
			pending = 0;
			results_checked = 0;
			fail_count = 0;
			ticks_seen = 0;
			admitted = 0;
			bad_rejects = 0;
			full_rejects = 0;
			completions = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					report_failure("result transaction with nothing outstanding");
				end else begin
					want = due_results.pop_front();
					check_field("status", status, want.status);
					check_field("first_busy", first_busy, want.first_busy);
					check_field("first_task", first_task, want.first_task);
					check_field("first_finished", first_finished, want.first_finished);
					check_field("second_busy", second_busy, want.second_busy);
					check_field("second_task", second_task, want.second_task);
					check_field("second_finished", second_finished, want.second_finished);
					check_field("table_empty", table_empty, want.table_empty);
					check_field("time_now", time_now, want.time_now);
				end
				results_checked++;
			end
			if (in_valid && in_ready) begin
				want = predict_schedule(op_t'(operation), task_id, task_priority,
					burst_length);
				due_results.push_back(want);
				if (op_t'(operation) == OP_TICK) begin
					ticks_seen++;
					completions += want.first_finished + want.second_finished;
				end else begin
					case (want.status)
						ST_OK:       admitted++;
						ST_BAD_ARGS: bad_rejects++;
						default:     full_rejects++;
					endcase
				end
			end
			pending = due_results.size();
		end
	end

endmodule

>>> tb/sv/tb_dual_server_priority_scheduler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dual_server_priority_scheduler - stimulus and verdict for the scheduler
// Drives a directed opening (an empty tick, bad arguments, a full table) and
// then random phases that fill, mix and drain the ready table, with bursty
// input, a receiver that stalls on its own pattern and one long hold-off.
// ----------------------------------------------------------------------------
module tb_dual_server_priority_scheduler;
	import dsps_pkg::*;

	localparam int    SLOTS        = 16;
	localparam int    TIME_BITS    = 16;
	localparam int    RANDOM_ITEMS = 1150;
	localparam int    LONG_HOLD    = 400;
	localparam int    DRAIN_CYCLES = 60;
	localparam longint RUN_LIMIT_NS = 30_000_000;

	logic        clk           = 1'b1;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic        operation     = 1'b0;
	logic [7:0]  task_id       = 8'd0;
	logic [7:0]  task_priority = 8'd0;
	logic [15:0] burst_length  = 16'd0;
	logic        out_ready     = 1'b0;

	logic        in_ready;
	logic        out_valid;
	logic [1:0]  status;
	logic        first_busy;
	logic [7:0]  first_task;
	logic        first_finished;
	logic        second_busy;
	logic [7:0]  second_task;
	logic        second_finished;
	logic        table_empty;
	logic [15:0] time_now;

	int fail_count;
	int pending;
	int ticks_seen;
	int admitted;
	int bad_rejects;
	int full_rejects;
	int completions;

	// long receiver hold-off requests and grants
	int hold_asked  = 0;
	int hold_served = 0;

	dual_server_priority_scheduler #(
		.TABLE_SLOTS(SLOTS),
		.TIME_BITS  (TIME_BITS)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.task_id        (task_id),
		.task_priority  (task_priority),
		.burst_length   (burst_length),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.first_busy     (first_busy),
		.first_task     (first_task),
		.first_finished (first_finished),
		.second_busy    (second_busy),
		.second_task    (second_task),
		.second_finished(second_finished),
		.table_empty    (table_empty),
		.time_now       (time_now)
	);

	scheduler_checker #(
		.SLOTS    (SLOTS),
		.TIME_BITS(TIME_BITS)
	) u_scheduler_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.task_id        (task_id),
		.task_priority  (task_priority),
		.burst_length   (burst_length),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.first_busy     (first_busy),
		.first_task     (first_task),
		.first_finished (first_finished),
		.second_busy    (second_busy),
		.second_task    (second_task),
		.second_finished(second_finished),
		.table_empty    (table_empty),
		.time_now       (time_now),
		.fail_count     (fail_count),
		.pending        (pending),
		.ticks_seen     (ticks_seen),
		.admitted       (admitted),
		.bad_rejects    (bad_rejects),
		.full_rejects   (full_rejects),
		.completions    (completions)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b0;
		#10 clk = 1'b1;
	end

	// offer one transaction and hold it until accepted
	task automatic send_item(op_t op, logic [7:0] id, logic [7:0] prio, logic [15:0] len);
		@(negedge clk);
		in_valid <= 1'b1;
		operation <= op;
		task_id <= id;
		task_priority <= prio;
		burst_length <= len;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// drop valid for a number of cycles
	task automatic idle_for(int n);
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// build one random transaction; tick_pct sets the share of ticks
	task automatic send_random(int tick_pct);
		op_t         op;
		logic [7:0]  id;
		logic [7:0]  prio;
		logic [15:0] len;
		int          r;
		id = 8'($urandom);
		prio = 8'($urandom);
		len = 16'($urandom);
		r = $urandom_range(0, 99);
		if (r < tick_pct) begin
			op = OP_TICK;
		end else begin
			op = OP_ADD;
			r = $urandom_range(0, 99);
			if (r < 4) begin
				prio = 8'd0;
			end else if (r < 8) begin
				len = 16'd0;
			end else begin
				// crowd priorities into a narrow band so ties are common
				if ($urandom_range(0, 1))
					prio = 8'($urandom_range(1, 4));
				else
					prio = 8'($urandom_range(1, 255));
				r = $urandom_range(0, 99);
				if (r < 80)
					len = 16'($urandom_range(1, 4));
				else if (r < 95)
					len = 16'($urandom_range(5, 20));
				else
					len = 16'($urandom_range(21, 120));
			end
		end
		send_item(op, id, prio, len);
	endtask

	// receiver: stall on a changing pattern, honour long hold-off requests
	initial begin
		int mode;
		int span;
		int cyc;
		cyc = 0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 150);
			repeat (span) begin
				@(negedge clk);
				cyc++;
				if (hold_served != hold_asked) begin
					out_ready <= 1'b0;
					repeat (LONG_HOLD) @(negedge clk);
					hold_served++;
				end
				case (mode)
					0:       out_ready <= 1'b1;
					1:       out_ready <= 1'($urandom_range(0, 1));
					2:       out_ready <= ($urandom_range(0, 5) == 0);
					default: out_ready <= (cyc % 4 != 0);
				endcase
			end
		end
	end

	// stimulus and verdict
	initial begin
		int          left;
		int          phase;
		int          phase_len;
		int          burst_cnt;
		int          tick_pct;
		int          r;
		logic [7:0]  fill_id;
		logic [7:0]  fill_prio;
		logic [15:0] fill_len;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// tick on an empty table, then adds with zero priority or burst
		send_item(OP_TICK, 8'h5A, 8'hFF, 16'hFFFF);
		send_item(OP_ADD, 8'h00, 8'h00, 16'hFFFF);
		send_item(OP_ADD, 8'hFF, 8'hFF, 16'h0000);
		send_item(OP_ADD, 8'hA5, 8'h00, 16'h0000);

		// fill every slot, mixing extremes and priority ties
		for (int k = 0; k < SLOTS; k++) begin
			fill_id = 8'(k * 17);
			fill_prio = 8'(2 + k % 3);
			fill_len = 16'(1 + k % 4);
			if (k == 0) begin
				fill_id = 8'hFF;
				fill_prio = 8'hFF;
				fill_len = 16'd1;
			end else if (k == 1) begin
				fill_id = 8'h00;
				fill_prio = 8'h01;
				fill_len = 16'd300;
			end
			send_item(OP_ADD, fill_id, fill_prio, fill_len);
		end

		// full table, then bad arguments on a full table, then serve
		send_item(OP_ADD, 8'h77, 8'h07, 16'h0005);
		send_item(OP_ADD, 8'h78, 8'h00, 16'h0009);
		repeat (3) send_item(OP_TICK, 8'($urandom), 8'($urandom), 16'($urandom));

		idle_for(1);
		wait (pending == 0);

		// random phases: fill, mixed or drain
		left = RANDOM_ITEMS;
		phase = 0;
		while (left > 0) begin
			case (phase == 0 ? 0 : $urandom_range(0, 2))
				0:       tick_pct = 25;
				1:       tick_pct = 50;
				default: tick_pct = 80;
			endcase
			phase_len = $urandom_range(60, 180);
			if (phase == 2)
				hold_asked++;
			while (phase_len > 0 && left > 0) begin
				burst_cnt = $urandom_range(1, 24);
				while (burst_cnt > 0 && phase_len > 0 && left > 0) begin
					send_random(tick_pct);
					burst_cnt--;
					phase_len--;
					left--;
				end
				r = $urandom_range(0, 99);
				if (r < 15)
					idle_for(0);
				else if (r < 75)
					idle_for($urandom_range(1, 5));
				else if (r < 92)
					idle_for($urandom_range(6, 25));
				else
					idle_for($urandom_range(26, 60));
			end
			// after the first phase, and after others at random, pause the sender until every outstanding result is back
			if (phase == 0 || $urandom_range(0, 1)) begin
				idle_for(1);
				wait (pending == 0);
			end
			phase++;
		end

		idle_for(1);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d transactions: %0d ticks, %0d tasks admitted, %0d completions.",
			ticks_seen + admitted + bad_rejects + full_rejects, ticks_seen, admitted,
			completions);
		$display("Rejected adds: %0d for zero priority or burst, %0d on a full table.",
			bad_rejects, full_rejects);
		if (fail_count == 0 && pending == 0)
			$display("** dual_server_priority_scheduler: PASSED **");
		else
			$display("** dual_server_priority_scheduler: FAILED **");
		$finish;
	end

	// stop a hung run
	initial begin
		#(RUN_LIMIT_NS);
		$display("** dual_server_priority_scheduler: FAILED **");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/dsps_pkg.sv
rtl/core/dsps_ctrl.sv
rtl/core/dsps_dp.sv
rtl/core/dual_server_priority_scheduler.sv
rtl/core/dsps_chk.sv
tb/sv/scheduler_checker.sv
tb/sv/tb_dual_server_priority_scheduler.sv
